// ----- rtl/core/qpn_pkg.sv -----
package qpn_pkg;

  localparam int CW    = 16;
  localparam int FRAC  = CW - 2;
  localparam int PW    = 2 * CW;
  localparam int SW    = PW + 2;
  localparam int MW    = PW + 1;
  localparam int NB    = 31;
  localparam int LW    = $clog2(MW + 1);
  localparam int SQW   = 2 * NB + 2;
  localparam int RTW   = SQW / 2;
  localparam int REMW  = RTW + 2;
  localparam int DW    = RTW + 1;
  localparam int QW    = FRAC + 1;
  localparam int NLANE = 4;
  localparam int SQ_STAGES  = RTW;
  localparam int DIV_STAGES = QW;

  typedef logic signed [CW-1:0] comp_t;

  typedef struct packed {
    logic                           v;
    logic                           zero;
    logic [NLANE-1:0]               neg;
    logic [NLANE-1:0][NB-1:0]       m;
  } norm_t;

  typedef struct packed {
    norm_t                          c;
    logic [REMW-1:0]                rem;
    logic [RTW-1:0]                 root;
    logic [SQW-1:0]                 rad;
  } sqrt_t;

  typedef struct packed {
    logic                           v;
    logic                           zero;
    logic [NLANE-1:0]               neg;
    logic [RTW-1:0]                 mag;
    logic [NLANE-1:0][DW-1:0]       rem;
    logic [NLANE-1:0][QW-1:0]       q;
  } div_t;

endpackage

// ----- rtl/core/quaternion_product_normalize_top.sv -----
// normalized hamilton product of two quaternions, signed q2.14 components
// input channel: in_valid / in_stall with a_* and b_* (x, y, z, scalar w)
// output channel: out_valid / out_stall with r_x, r_y, r_z, r_w and
// zero_magnitude, set when the product is exactly zero (components then 0)
// a transaction moves when valid is high and stall is low
// throughput is one transaction per cycle while the receiver does not stall;
// the pipeline is 7 stages of multiply, sum, magnitude and normalize, a 32
// stage square root pipeline (one root bit per stage), a setup stage, a 15
// stage divider (one quotient bit per stage, four lanes) and the output register
// when the receiver stalls while out_valid is high the whole pipeline
// holds and in_stall is raised in the same cycle; nothing is dropped
// synchronous reset clears all valid bits; no item is in flight after it
module quaternion_product_normalize_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  qpn_pkg::comp_t a_x,
  input  qpn_pkg::comp_t a_y,
  input  qpn_pkg::comp_t a_z,
  input  qpn_pkg::comp_t a_w,
  input  qpn_pkg::comp_t b_x,
  input  qpn_pkg::comp_t b_y,
  input  qpn_pkg::comp_t b_z,
  input  qpn_pkg::comp_t b_w,
  output logic           out_valid,
  input  logic           out_stall,
  output qpn_pkg::comp_t r_x,
  output qpn_pkg::comp_t r_y,
  output qpn_pkg::comp_t r_z,
  output qpn_pkg::comp_t r_w,
  output logic           zero_magnitude
);
  import qpn_pkg::*;

  function automatic logic signed [SW-1:0] sx(input logic signed [PW-1:0] p);
    sx = SW'(p);
  endfunction

  function automatic logic [LW-1:0] bit_len(input logic [MW-1:0] v);
    logic [LW-1:0] n;
    n = '0;
    for (int i = 0; i < MW; i++) begin
      if (v[i]) n = LW'(i + 1);
    end
    return n;
  endfunction

  function automatic sqrt_t sq_step(input sqrt_t s);
    sqrt_t            o;
    logic [REMW+1:0]  r2;
    logic [REMW+1:0]  trial;
    logic             ge;
    o     = s;
    r2    = {s.rem, s.rad[SQW-1 -: 2]};
    trial = {2'b00, s.root, 2'b01};
    ge    = (r2 >= trial);
    o.rem  = ge ? REMW'(r2 - trial) : REMW'(r2);
    o.root = {s.root[RTW-2:0], ge};
    o.rad  = {s.rad[SQW-3:0], 2'b00};
    return o;
  endfunction

  function automatic div_t div_step(input div_t d, input int j);
    div_t           o;
    logic [DW:0]    r2;
    logic [DW:0]    den;
    logic           ge;
    o   = d;
    den = {1'b0, d.mag, 1'b0};
    for (int l = 0; l < NLANE; l++) begin
      r2 = {d.rem[l], d.mag[FRAC - j]};
      ge = (r2 >= den);
      o.rem[l] = ge ? DW'(r2 - den) : DW'(r2);
      o.q[l]   = {d.q[l][QW-2:0], ge};
    end
    return o;
  endfunction

  logic                                en;

  // stage 1: products
  logic                                v1;
  logic signed [PW-1:0]                pr [NLANE][NLANE];
  // stage 2: component sums
  logic                                v2;
  logic signed [SW-1:0]                ps [NLANE];
  // stage 3: sign and magnitude
  logic                                v3;
  logic [NLANE-1:0]                    neg3;
  logic [MW-1:0]                       mag3 [NLANE];
  // stage 4: leading bit position
  logic                                v4;
  logic [NLANE-1:0]                    neg4;
  logic [MW-1:0]                       mag4 [NLANE];
  logic [LW-1:0]                       len4;
  // stage 5: normalized magnitudes
  norm_t                               n5;
  // stage 6: squares
  norm_t                               n6;
  logic [2*NB-1:0]                     sq6 [NLANE];
  // stage 7: sum of squares
  norm_t                               n7;
  logic [SQW-1:0]                      sum7;

  sqrt_t                               sq_in;
  sqrt_t                               sq [1:SQ_STAGES];
  div_t                                dv [DIV_STAGES+1];

  comp_t                               a_in [NLANE];
  comp_t                               b_in [NLANE];

  assign a_in[0] = a_x;
  assign a_in[1] = a_y;
  assign a_in[2] = a_z;
  assign a_in[3] = a_w;
  assign b_in[0] = b_x;
  assign b_in[1] = b_y;
  assign b_in[2] = b_z;
  assign b_in[3] = b_w;

  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  always_comb begin
    sq_in        = '0;
    sq_in.c      = n7;
    sq_in.rad    = sum7;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      n5.v      <= 1'b0;
      n6.v      <= 1'b0;
      n7.v      <= 1'b0;
      for (int k = 1; k <= SQ_STAGES; k++) sq[k].c.v <= 1'b0;
      for (int k = 0; k <= DIV_STAGES; k++) dv[k].v <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      for (int i = 0; i < NLANE; i++) begin
        for (int j = 0; j < NLANE; j++) pr[i][j] <= PW'(a_in[i]) * PW'(b_in[j]);
      end

      v2    <= v1;
      ps[0] <= sx(pr[3][0]) + sx(pr[0][3]) + sx(pr[1][2]) - sx(pr[2][1]);
      ps[1] <= sx(pr[3][1]) - sx(pr[0][2]) + sx(pr[1][3]) + sx(pr[2][0]);
      ps[2] <= sx(pr[3][2]) + sx(pr[0][1]) - sx(pr[1][0]) + sx(pr[2][3]);
      ps[3] <= sx(pr[3][3]) - sx(pr[0][0]) - sx(pr[1][1]) - sx(pr[2][2]);

      v3 <= v2;
      for (int i = 0; i < NLANE; i++) begin
        neg3[i] <= ps[i][SW-1];
        mag3[i] <= ps[i][SW-1] ? MW'(-ps[i]) : MW'(ps[i]);
      end

      v4   <= v3;
      neg4 <= neg3;
      mag4 <= mag3;
      len4 <= bit_len(mag3[0] | mag3[1] | mag3[2] | mag3[3]);

      n5.v    <= v4;
      n5.zero <= (len4 == '0);
      n5.neg  <= neg4;
      for (int i = 0; i < NLANE; i++) begin
        if (len4 >= LW'(NB)) n5.m[i] <= NB'(mag4[i] >> (len4 - LW'(NB)));
        else                 n5.m[i] <= NB'(mag4[i] << (LW'(NB) - len4));
      end

      n6 <= n5;
      for (int i = 0; i < NLANE; i++) sq6[i] <= (2*NB)'(n5.m[i]) * (2*NB)'(n5.m[i]);

      n7   <= n6;
      sum7 <= SQW'(sq6[0]) + SQW'(sq6[1]) + SQW'(sq6[2]) + SQW'(sq6[3]);

      sq[1] <= sq_step(sq_in);
      for (int k = 1; k < SQ_STAGES; k++) sq[k+1] <= sq_step(sq[k]);

      // divider setup: high part of (m << (frac+1)) + mag, low bits fed per step
      dv[0].v    <= sq[SQ_STAGES].c.v;
      dv[0].zero <= sq[SQ_STAGES].c.zero;
      dv[0].neg  <= sq[SQ_STAGES].c.neg;
      dv[0].mag  <= sq[SQ_STAGES].root;
      dv[0].q    <= '0;
      for (int i = 0; i < NLANE; i++) begin
        dv[0].rem[i] <= DW'(sq[SQ_STAGES].c.m[i])
                      + DW'(sq[SQ_STAGES].root[RTW-1:QW]);
      end

      for (int k = 0; k < DIV_STAGES; k++) dv[k+1] <= div_step(dv[k], k);

      out_valid      <= dv[DIV_STAGES].v;
      zero_magnitude <= dv[DIV_STAGES].zero;
      if (dv[DIV_STAGES].zero) begin
        r_x <= '0;
        r_y <= '0;
        r_z <= '0;
        r_w <= '0;
      end else begin
        r_x <= dv[DIV_STAGES].neg[0] ? -comp_t'(dv[DIV_STAGES].q[0])
                                     : comp_t'(dv[DIV_STAGES].q[0]);
        r_y <= dv[DIV_STAGES].neg[1] ? -comp_t'(dv[DIV_STAGES].q[1])
                                     : comp_t'(dv[DIV_STAGES].q[1]);
        r_z <= dv[DIV_STAGES].neg[2] ? -comp_t'(dv[DIV_STAGES].q[2])
                                     : comp_t'(dv[DIV_STAGES].q[2]);
        r_w <= dv[DIV_STAGES].neg[3] ? -comp_t'(dv[DIV_STAGES].q[3])
                                     : comp_t'(dv[DIV_STAGES].q[3]);
      end
    end
  end

  // zero product forces all components to zero
  a_zero_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && zero_magnitude |-> r_x == '0 && r_y == '0 && r_z == '0 && r_w == '0)
    else $error("zero product with nonzero components");

  // a unit quaternion always has a nonzero component
  a_unit_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && !zero_magnitude |-> r_x != '0 || r_y != '0 || r_z != '0 || r_w != '0)
    else $error("nonzero product gave all zero components");

  // normalization puts the root of a nonzero sum in the top two bits
  a_root_range: assert property (@(posedge clk) disable iff (rst)
    sq[SQ_STAGES].c.v && !sq[SQ_STAGES].c.zero |-> sq[SQ_STAGES].root[RTW-1 -: 2] != 2'b00)
    else $error("square root out of normalized range");

endmodule

// ----- tb/sv/tb_quaternion_product_normalize_top.sv -----
module tb_quaternion_product_normalize_top;
  import qpn_pkg::*;

  typedef struct {
    comp_t x;
    comp_t y;
    comp_t z;
    comp_t w;
    logic  zero;
  } unit_quat_t;

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_stall;
  comp_t a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w;
  logic  out_valid;
  logic  out_stall;
  comp_t r_x, r_y, r_z, r_w;
  logic  zero_magnitude;

  unit_quat_t expected_q[$];
  int         errors;
  int         cycles;
  int         send_idle_pct;
  int         stall_pct;

  localparam int LIMIT = 400000;

  quaternion_product_normalize_top u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .a_x(a_x), .a_y(a_y), .a_z(a_z), .a_w(a_w),
    .b_x(b_x), .b_y(b_y), .b_z(b_z), .b_w(b_w),
    .out_valid(out_valid), .out_stall(out_stall),
    .r_x(r_x), .r_y(r_y), .r_z(r_z), .r_w(r_w),
    .zero_magnitude(zero_magnitude)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic unit_quat_t normalized_product(comp_t ax, comp_t ay, comp_t az,
                                                     comp_t aw, comp_t bx, comp_t by,
                                                     comp_t bz, comp_t bw);
    longint        p[4];
    logic [63:0]   amag[4];
    logic          neg[4];
    logic [63:0]   m[4];
    logic [63:0]   s;
    logic [63:0]   root;
    logic [63:0]   rem;
    logic [63:0]   bitv;
    logic [63:0]   q;
    comp_t         o[4];
    int            maxlen;
    int            len;
    int            sh;
    unit_quat_t    r;
    p[0] = longint'(aw) * bx + longint'(ax) * bw + longint'(ay) * bz - longint'(az) * by;
    p[1] = longint'(aw) * by - longint'(ax) * bz + longint'(ay) * bw + longint'(az) * bx;
    p[2] = longint'(aw) * bz + longint'(ax) * by - longint'(ay) * bx + longint'(az) * bw;
    p[3] = longint'(aw) * bw - longint'(ax) * bx - longint'(ay) * by - longint'(az) * bz;
    maxlen = 0;
    for (int i = 0; i < 4; i++) begin
      neg[i] = p[i] < 0;
      amag[i] = neg[i] ? -p[i] : p[i];
      len = 0;
      for (int k = 0; k < 64; k++) if (amag[i][k]) len = k + 1;
      if (len > maxlen) maxlen = len;
    end
    if (maxlen == 0) begin
      r.x = '0; r.y = '0; r.z = '0; r.w = '0; r.zero = 1'b1;
      return r;
    end
    sh = maxlen - NB;
    s = '0;
    for (int i = 0; i < 4; i++) begin
      m[i] = (sh > 0) ? (amag[i] >> sh) : (amag[i] << (-sh));
      s += m[i] * m[i];
    end
    // bitwise integer square root
    root = '0;
    rem = s;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    for (int i = 0; i < 4; i++) begin
      q = ((m[i] << (FRAC + 1)) + root) / (2 * root);
      if (q > 64'd32767) q = 64'd32767;
      o[i] = neg[i] ? comp_t'(-q) : comp_t'(q);
    end
    r.x = o[0]; r.y = o[1]; r.z = o[2]; r.w = o[3]; r.zero = 1'b0;
    return r;
  endfunction

  task automatic send_quats(comp_t ax, comp_t ay, comp_t az, comp_t aw,
                            comp_t bx, comp_t by, comp_t bz, comp_t bw);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    a_x <= ax; a_y <= ay; a_z <= az; a_w <= aw;
    b_x <= bx; b_y <= by; b_z <= bz; b_w <= bw;
    expected_q.push_back(normalized_product(ax, ay, az, aw, bx, by, bz, bw));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic release_input();
    in_valid <= 1'b0;
  endtask

  function automatic comp_t rand_comp();
    case ($urandom_range(5))
      0: rand_comp = comp_t'($urandom_range(0, 3) == 0 ? 16'h8000 : 16'h7fff);
      1: rand_comp = comp_t'($urandom_range(0, 7)) - comp_t'(4);
      2: rand_comp = comp_t'($urandom_range(0, 32767)) - comp_t'(16384);
      default: rand_comp = comp_t'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    comp_t mn;
    comp_t mx;
    mn = comp_t'(16'h8000);
    mx = comp_t'(16'h7fff);
    send_quats(0, 0, 0, 0, 0, 0, 0, 0);
    send_quats(1, 2, 3, 4, 0, 0, 0, 0);
    send_quats(0, 0, 0, 16384, 0, 0, 0, 16384);
    send_quats(16384, 0, 0, 0, 0, 16384, 0, 0);
    send_quats(mx, mx, mx, mx, mx, mx, mx, mx);
    send_quats(mn, mn, mn, mn, mn, mn, mn, mn);
    send_quats(mn, mx, mn, mx, mx, mn, mx, mn);
    send_quats(0, 0, 0, 1, 0, 0, 0, 1);
    send_quats(0, 0, 0, -1, 1, 0, 0, 0);
    send_quats(1, 0, 0, 0, 0, 0, 0, -1);
    send_quats(mn, 0, 0, 0, mn, 0, 0, 0);
    send_quats(-1, -1, -1, -1, -1, -1, -1, -1);
    send_quats(1, 1, 0, 0, 1, -1, 0, 0);
    send_quats(16'sh5555, -16'sh2aab, 16'sh1234, -16'sh0f0f,
               -16'sh7654, 16'sh0101, 16'sh7f00, -16'sh00ff);
  endtask

  task automatic test_random(int n, int idle_pct, int hold_pct);
    send_idle_pct = idle_pct;
    stall_pct = hold_pct;
    for (int i = 0; i < n; i++) begin
      send_quats(rand_comp(), rand_comp(), rand_comp(), rand_comp(),
                 rand_comp(), rand_comp(), rand_comp(), rand_comp());
    end
  endtask

  // receiver stall
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // result check
  always @(posedge clk) begin
    unit_quat_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t unexpected transaction r=%h %h %h %h z=%b", $time,
                 r_x, r_y, r_z, r_w, zero_magnitude);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (r_x !== e.x) begin
          $display("%0t r_x expected %0d actual %0d", $time, e.x, r_x); errors++;
        end
        if (r_y !== e.y) begin
          $display("%0t r_y expected %0d actual %0d", $time, e.y, r_y); errors++;
        end
        if (r_z !== e.z) begin
          $display("%0t r_z expected %0d actual %0d", $time, e.z, r_z); errors++;
        end
        if (r_w !== e.w) begin
          $display("%0t r_w expected %0d actual %0d", $time, e.w, r_w); errors++;
        end
        if (zero_magnitude !== e.zero) begin
          $display("%0t zero_magnitude expected %b actual %b", $time, e.zero,
                   zero_magnitude);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    errors = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    {a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w} = '0;
    out_stall = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(150, 0, 0);
    test_random(130, 69, 0);
    test_random(130, 0, 69);
    test_random(130, 22, 22);
    release_input();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/qpn_pkg.sv
rtl/core/quaternion_product_normalize_top.sv
tb/sv/tb_quaternion_product_normalize_top.sv
